// File: rtl/core/arp_cache_resolver_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef ARP_CACHE_RESOLVER_UNIT_MACROS_SVH
`define ARP_CACHE_RESOLVER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ARPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/arpc_pkg.sv
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// item op codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// ARP operation on the wire
	localparam logic [15:0] PKT_OPC_REQ = 16'd1;

	// result kinds
	localparam logic [1:0] KIND_HIT   = 2'd0;
	localparam logic [1:0] KIND_MISS  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// outgoing opcodes
	localparam logic [1:0] OUT_OPC_NONE = 2'd0;
	localparam logic [1:0] OUT_OPC_REQ  = 2'd1;
	localparam logic [1:0] OUT_OPC_REP  = 2'd2;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

	// register select, taken from paddr[3]
	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] lookup_ip;
		logic [15:0] pkt_opcode;
		logic [47:0] pkt_sender_mac;
		logic [31:0] pkt_sender_ip;
		logic [31:0] pkt_target_ip;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [47:0] found_mac;
		logic [1:0]  out_opcode;
		logic [47:0] out_dest_mac;
		logic [47:0] out_sender_mac;
		logic [31:0] out_sender_ip;
		logic [47:0] out_target_mac;
		logic [31:0] out_target_ip;
	} result_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} cache_rd_req_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
	} cache_rd_data_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      ip;
		logic [47:0]      mac;
	} cache_wr_t;

endpackage

// File: rtl/core/arpc_item_if.sv
interface arpc_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] lookup_ip;
	logic [15:0] pkt_opcode;
	logic [47:0] pkt_sender_mac;
	logic [31:0] pkt_sender_ip;
	logic [31:0] pkt_target_ip;

	modport source (
		output valid, op, lookup_ip, pkt_opcode, pkt_sender_mac, pkt_sender_ip,
		       pkt_target_ip,
		input  ready
	);
	modport sink (
		input  valid, op, lookup_ip, pkt_opcode, pkt_sender_mac, pkt_sender_ip,
		       pkt_target_ip,
		output ready
	);
endinterface

// File: rtl/core/arpc_result_if.sv
interface arpc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [47:0] found_mac;
	logic [1:0]  out_opcode;
	logic [47:0] out_dest_mac;
	logic [47:0] out_sender_mac;
	logic [31:0] out_sender_ip;
	logic [47:0] out_target_mac;
	logic [31:0] out_target_ip;

	modport source (
		output valid, result_kind, found_mac, out_opcode, out_dest_mac, out_sender_mac,
		       out_sender_ip, out_target_mac, out_target_ip,
		input  ready
	);
	modport sink (
		input  valid, result_kind, found_mac, out_opcode, out_dest_mac, out_sender_mac,
		       out_sender_ip, out_target_mac, out_target_ip,
		output ready
	);
endinterface

// File: rtl/core/arpc_cache.sv
// IP/MAC store, one read and one write port, registered read.
module arpc_cache (
	input  logic                     clk,
	input  logic                     arst_n,
	input  arpc_pkg::cache_rd_req_t  rd_req,
	output arpc_pkg::cache_rd_data_t rd_data,
	input  arpc_pkg::cache_wr_t      wr
);

	logic [31:0]                  ip_mem  [arpc_pkg::ENTRIES];
	logic [47:0]                  mac_mem [arpc_pkg::ENTRIES];
	logic [arpc_pkg::ENTRIES-1:0] valid_q;

	logic        rd_vld_q;
	logic [31:0] rd_ip_q;
	logic [47:0] rd_mac_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ip_mem[wr.idx]  <= wr.ip;
			mac_mem[wr.idx] <= wr.mac;
		end
		if (rd_req.en) begin
			rd_ip_q  <= ip_mem[rd_req.idx];
			rd_mac_q <= mac_mem[rd_req.idx];
		end
	end

	// valid flags clear on reset so unwritten slots never match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_vld_q <= valid_q[rd_req.idx];
			end
		end
	end

	assign rd_data.valid = rd_vld_q;
	assign rd_data.ip    = rd_ip_q;
	assign rd_data.mac   = rd_mac_q;

endmodule

// File: rtl/core/arpc_seq.sv
// Scan sequencer: one comparator walks the cache, then update and, where one is due, result.
module arpc_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  arpc_pkg::item_t          item,
	input  logic [47:0]              own_mac,
	input  logic [31:0]              own_ip,
	output logic                     res_valid,
	input  logic                     res_ready,
	output arpc_pkg::result_t        res,
	output arpc_pkg::cache_rd_req_t  rd_req,
	input  arpc_pkg::cache_rd_data_t rd_data,
	output arpc_pkg::cache_wr_t      wr
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q;

	logic                       op_q;
	logic                       is_req_q;
	logic [31:0]                key_q;
	logic [47:0]                smac_q;
	logic                       hit_q;
	logic [arpc_pkg::IDX_W-1:0] slot_q;
	logic [47:0]                mac_q;
	logic [arpc_pkg::IDX_W-1:0] cursor_q;

	logic [arpc_pkg::IDX_W-1:0] rd_idx_q;
	logic                       issue_q;
	logic                       cmp_vld_s1;
	logic [arpc_pkg::IDX_W-1:0] cmp_idx_s1;

	logic accept;
	logic for_us;
	logic match;
	logic last_cmp;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign for_us     = (item.op == arpc_pkg::OP_LOOKUP) || (item.pkt_target_ip == own_ip);

	// the shared comparator
	assign match    = cmp_vld_s1 && rd_data.valid && (rd_data.ip == key_q);
	assign last_cmp = cmp_vld_s1 && (cmp_idx_s1 == arpc_pkg::LAST_IDX);

	assign rd_req.en  = (state_q == ST_SCAN) && issue_q;
	assign rd_req.idx = rd_idx_q;

	assign wr.en  = (state_q == ST_UPDATE) && (op_q == arpc_pkg::OP_PACKET);
	assign wr.idx = hit_q ? slot_q : cursor_q;
	assign wr.ip  = key_q;
	assign wr.mac = smac_q;

	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		res = '0;
		if (op_q == arpc_pkg::OP_LOOKUP && hit_q) begin
			res.result_kind = arpc_pkg::KIND_HIT;
			res.found_mac   = mac_q;
		end else if (op_q == arpc_pkg::OP_LOOKUP) begin
			res.result_kind    = arpc_pkg::KIND_MISS;
			res.out_opcode     = arpc_pkg::OUT_OPC_REQ;
			res.out_dest_mac   = arpc_pkg::BCAST_MAC;
			res.out_sender_mac = own_mac;
			res.out_sender_ip  = own_ip;
			res.out_target_ip  = key_q;
		end else begin
			res.result_kind    = arpc_pkg::KIND_REPLY;
			res.out_opcode     = arpc_pkg::OUT_OPC_REP;
			res.out_dest_mac   = smac_q;
			res.out_sender_mac = own_mac;
			res.out_sender_ip  = own_ip;
			res.out_target_mac = smac_q;
			res.out_target_ip  = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= item.op;
			is_req_q <= (item.pkt_opcode == arpc_pkg::PKT_OPC_REQ);
			key_q    <= (item.op == arpc_pkg::OP_LOOKUP) ? item.lookup_ip : item.pkt_sender_ip;
			smac_q   <= item.pkt_sender_mac;
		end
		if (state_q == ST_SCAN && match) begin
			slot_q <= cmp_idx_s1;
			mac_q  <= rd_data.mac;
		end
		cmp_idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hit_q      <= 1'b0;
			cursor_q   <= '0;
			rd_idx_q   <= '0;
			issue_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					rd_idx_q   <= '0;
					issue_q    <= 1'b1;
					hit_q      <= 1'b0;
					if (accept && for_us) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue_q;
					if (issue_q) begin
						if (rd_idx_q == arpc_pkg::LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else if (last_cmp) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cmp_vld_s1 <= 1'b0;
					if (wr.en && !hit_q) begin
						cursor_q <= (cursor_q == arpc_pkg::LAST_IDX) ? '0 : cursor_q + 1'b1;
					end
					if (op_q == arpc_pkg::OP_LOOKUP || is_req_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/arp_cache_resolver_unit.sv
// ARP resolver with a 16-entry IP-to-MAC cache. A lookup beat returns the
// cached MAC on a hit, or a broadcast ARP request on a miss; a received-packet
// beat is dropped unless its target IP is own_ip, then its sender is learnt
// (matching entry updated, else the round-robin slot overwritten) and a
// request is answered with a reply. One item at a time. The cache is
// walked one entry per clock through a single registered read port and one
// 32-bit comparator; the scan stops at the first hit, else runs over all 16
// entries. An update step follows (it writes for packets only), then, for a
// lookup or a request packet, a result step that waits while the output
// register is full and not drained. A packet not addressed to us is dropped
// at accept without a scan. The result sits in an output register, so the
// next item is taken while it waits. Config (APB): own_mac at 0x0, own_ip at
// 0x8; write only while no item is in flight.
module arp_cache_resolver_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	arpc_item_if.sink            item,
	arpc_result_if.source        result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;

	arpc_pkg::item_t          item_d;
	arpc_pkg::result_t        res;
	arpc_pkg::result_t        res_q;
	logic                     res_valid;
	logic                     res_ready;
	logic                     out_vld_q;
	arpc_pkg::cache_rd_req_t  rd_req;
	arpc_pkg::cache_rd_data_t rd_data;
	arpc_pkg::cache_wr_t      wr;

	// --- config registers; paddr[3] picks the register, low bits are lane bits
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3])
				arpc_pkg::REG_OWN_MAC: own_mac_q <= pwdata[47:0];
				arpc_pkg::REG_OWN_IP:  own_ip_q  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			arpc_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac_q};
			arpc_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip_q};
			default:               prdata = '0;
		endcase
	end

	// --- input beat
	assign item_d.op             = item.op;
	assign item_d.lookup_ip      = item.lookup_ip;
	assign item_d.pkt_opcode     = item.pkt_opcode;
	assign item_d.pkt_sender_mac = item.pkt_sender_mac;
	assign item_d.pkt_sender_ip  = item.pkt_sender_ip;
	assign item_d.pkt_target_ip  = item.pkt_target_ip;

	arpc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.item       (item_d),
		.own_mac    (own_mac_q),
		.own_ip     (own_ip_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.rd_req     (rd_req),
		.rd_data    (rd_data),
		.wr         (wr)
	);

	arpc_cache u_cache (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.wr      (wr)
	);

	// --- output register: refilled when empty or being drained this cycle
	assign res_ready = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.result_kind    = res_q.result_kind;
	assign result.found_mac      = res_q.found_mac;
	assign result.out_opcode     = res_q.out_opcode;
	assign result.out_dest_mac   = res_q.out_dest_mac;
	assign result.out_sender_mac = res_q.out_sender_mac;
	assign result.out_sender_ip  = res_q.out_sender_ip;
	assign result.out_target_mac = res_q.out_target_mac;
	assign result.out_target_ip  = res_q.out_target_ip;

endmodule

// File: rtl/core/arpc_checker.sv
`include "arp_cache_resolver_unit_macros.svh"

module arpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  result_kind,
	input logic [47:0] found_mac,
	input logic [1:0]  out_opcode,
	input logic [47:0] out_dest_mac,
	input logic [47:0] out_sender_mac,
	input logic [31:0] out_sender_ip,
	input logic [47:0] out_target_mac,
	input logic [31:0] out_target_ip
);

	`ARPC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(result_kind) && $stable(found_mac) && $stable(out_opcode) && $stable(out_dest_mac) && $stable(out_sender_mac) && $stable(out_sender_ip) && $stable(out_target_mac) && $stable(out_target_ip), "result beat changed while stalled")
	`ARPC_ASSERT_NOW(a_hit_clean, clk, arst_n, res_valid && result_kind == arpc_pkg::KIND_HIT, out_opcode == arpc_pkg::OUT_OPC_NONE && out_dest_mac == 48'd0 && out_target_ip == 32'd0, "hit carries packet fields")
	`ARPC_ASSERT_NOW(a_miss_req, clk, arst_n, res_valid && result_kind == arpc_pkg::KIND_MISS, out_opcode == arpc_pkg::OUT_OPC_REQ && out_dest_mac == arpc_pkg::BCAST_MAC && out_target_mac == 48'd0 && found_mac == 48'd0, "malformed ARP request")
	`ARPC_ASSERT_NOW(a_reply_dest, clk, arst_n, res_valid && result_kind == arpc_pkg::KIND_REPLY, out_opcode == arpc_pkg::OUT_OPC_REP && out_dest_mac == out_target_mac && found_mac == 48'd0, "malformed ARP reply")

endmodule

bind arp_cache_resolver_unit arpc_checker u_arpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.result_kind    (result.result_kind),
	.found_mac      (result.found_mac),
	.out_opcode     (result.out_opcode),
	.out_dest_mac   (result.out_dest_mac),
	.out_sender_mac (result.out_sender_mac),
	.out_sender_ip  (result.out_sender_ip),
	.out_target_mac (result.out_target_mac),
	.out_target_ip  (result.out_target_ip)
);
